// ----- hw/rtl/lpph_pkg.sv -----
package lpph_pkg;

    localparam int OUT_W = 32;

    localparam logic       OP_STREAM  = 1'b0;
    localparam logic       OP_READ    = 1'b1;
    localparam logic       KIND_FRAME = 1'b0;
    localparam logic       KIND_READ  = 1'b1;

    localparam logic [7:0] CHAR_MARK  = 8'h23;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] PRINT_LO   = 8'd32;
    localparam logic [7:0] PRINT_HI   = 8'd126;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_UPD,
        S_CHECK,
        S_MERGE,
        S_MTAIL,
        S_FIN
    } t_state;

    typedef struct packed {
        logic clr_wr;
        logic byte_acc;
        logic rd_acc;
        logic hist_upd;
        logic merge_rd;
        logic load_rd;
        logic load_fin;
    } t_cmd;

    typedef struct packed {
        logic is_read;
        logic in_payload;
        logic pay_hit;
        logic fin_now;
        logic frame_done;
        logic sweep_last;
        logic out_free;
    } t_stat;

endpackage

// ----- hw/rtl/lpph_ctrl.sv -----
module lpph_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  lpph_pkg::t_stat i_stat,
    output lpph_pkg::t_cmd  o_cmd
);

    lpph_pkg::t_state r_state;
    lpph_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lpph_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            lpph_pkg::S_CLEAR: begin
                if (i_stat.sweep_last) n_state = lpph_pkg::S_IDLE;
            end
            lpph_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    if (i_stat.is_read) begin
                        n_state = lpph_pkg::S_READ;
                    end else if (i_stat.in_payload) begin
                        n_state = i_stat.pay_hit ? lpph_pkg::S_UPD : lpph_pkg::S_CHECK;
                    end else if (i_stat.fin_now) begin
                        n_state = lpph_pkg::S_FIN;
                    end
                end
            end
            lpph_pkg::S_READ: begin
                if (i_stat.out_free) n_state = lpph_pkg::S_IDLE;
            end
            lpph_pkg::S_UPD: begin
                n_state = lpph_pkg::S_CHECK;
            end
            lpph_pkg::S_CHECK: begin
                n_state = i_stat.frame_done ? lpph_pkg::S_MERGE : lpph_pkg::S_IDLE;
            end
            lpph_pkg::S_MERGE: begin
                if (i_stat.sweep_last) n_state = lpph_pkg::S_MTAIL;
            end
            lpph_pkg::S_MTAIL: begin
                n_state = lpph_pkg::S_FIN;
            end
            lpph_pkg::S_FIN: begin
                if (i_stat.out_free) n_state = lpph_pkg::S_IDLE;
            end
            default: begin
                n_state = lpph_pkg::S_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            lpph_pkg::S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
            end
            lpph_pkg::S_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.rd_acc   = i_in_valid & i_stat.is_read;
                o_cmd.byte_acc = i_in_valid & ~i_stat.is_read;
            end
            lpph_pkg::S_READ: begin
                o_cmd.load_rd = i_stat.out_free;
            end
            lpph_pkg::S_UPD: begin
                o_cmd.hist_upd = 1'b1;
            end
            lpph_pkg::S_MERGE: begin
                o_cmd.merge_rd = 1'b1;
            end
            lpph_pkg::S_FIN: begin
                o_cmd.load_fin = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ----- hw/rtl/lpph_dp.sv -----
module lpph_dp #(
    parameter int NUM_BINS    = 95,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lpph_pkg::t_cmd               i_cmd,
    output lpph_pkg::t_stat              o_stat,
    input  logic                         i_op,
    input  logic [7:0]                   i_data_byte,
    input  logic [6:0]                   i_bin_index,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic                         o_kind,
    output logic [lpph_pkg::OUT_W-1:0]   o_printable_count,
    output logic [lpph_pkg::OUT_W-1:0]   o_bin_value,
    output logic [lpph_pkg::OUT_W-1:0]   o_payload_total
);

    localparam int CW = COUNT_WIDTH;
    localparam int LW = COUNT_WIDTH + 4;
    localparam int AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_BINS - 1);

    function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [CW-1:0] b);
        logic [CW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CW] ? '1 : s[CW-1:0];
    endfunction

    function automatic logic [lpph_pkg::OUT_W-1:0] low_out(input logic [CW-1:0] x);
        logic [63:0] w;
        w = 64'(x);
        return w[lpph_pkg::OUT_W-1:0];
    endfunction

    // Frame state.
    logic          r_in_payload;
    logic          r_digits_stopped;
    logic [CW-1:0] r_len;
    logic [CW-1:0] r_seen;
    logic [CW-1:0] r_printable;
    logic [CW-1:0] r_gbytes;

    // Histogram stores and their registered read data.
    logic [CW-1:0] mem_fh [NUM_BINS];
    logic [CW-1:0] mem_gh [NUM_BINS];
    logic [CW-1:0] r_fh_q;
    logic [CW-1:0] r_gh_q;

    logic [AW-1:0] r_cnt;
    logic          r_mwr;
    logic [AW-1:0] r_mwr_addr;
    logic [AW-1:0] r_k;
    logic          r_idx_ok;

    logic          r_out_valid;
    logic          r_kind;
    logic [lpph_pkg::OUT_W-1:0] r_out_pc;
    logic [lpph_pkg::OUT_W-1:0] r_out_bin;
    logic [lpph_pkg::OUT_W-1:0] r_out_total;

    logic          is_digit;
    logic          is_mark;
    logic          is_print;
    logic [8:0]    code_off;
    logic [8:0]    idx_ext;
    logic          idx_ok;
    logic [3:0]    digit;
    logic [LW-1:0] len_x10;
    logic [CW-1:0] len_next;
    logic [CW-1:0] gbytes_next;
    logic          out_free;
    logic          sweep_step;

    logic          fh_re;
    logic [AW-1:0] fh_raddr;
    logic          fh_we;
    logic [AW-1:0] fh_waddr;
    logic [CW-1:0] fh_wdata;
    logic          gh_re;
    logic [AW-1:0] gh_raddr;
    logic          gh_we;
    logic [AW-1:0] gh_waddr;
    logic [CW-1:0] gh_wdata;

    assign is_digit = (i_data_byte >= lpph_pkg::CHAR_ZERO) && (i_data_byte <= lpph_pkg::CHAR_NINE);
    assign is_mark  = (i_data_byte == lpph_pkg::CHAR_MARK);
    assign code_off = {1'b0, i_data_byte} - {1'b0, lpph_pkg::PRINT_LO};
    assign is_print = (i_data_byte >= lpph_pkg::PRINT_LO) && (i_data_byte <= lpph_pkg::PRINT_HI)
                      && (code_off < 9'(NUM_BINS));
    assign idx_ext  = {2'b00, i_bin_index};
    assign idx_ok   = idx_ext < 9'(NUM_BINS);
    assign digit    = 4'(i_data_byte - lpph_pkg::CHAR_ZERO);

    // Times ten as two shifts; any carry into the top nibble means overflow.
    assign len_x10  = (LW'(r_len) << 3) + (LW'(r_len) << 1) + LW'(digit);
    assign len_next = (|len_x10[LW-1:CW]) ? '1 : len_x10[CW-1:0];

    assign gbytes_next = sat_add(r_gbytes, r_len);
    assign out_free    = ~r_out_valid | i_out_ready;
    assign sweep_step  = i_cmd.clr_wr | i_cmd.merge_rd;

    assign o_stat.is_read    = (i_op == lpph_pkg::OP_READ);
    assign o_stat.in_payload = r_in_payload;
    assign o_stat.pay_hit    = is_print;
    assign o_stat.fin_now    = is_mark && (r_len == '0);
    assign o_stat.frame_done = (r_seen >= r_len);
    assign o_stat.sweep_last = (r_cnt == LAST_ADDR);
    assign o_stat.out_free   = out_free;

    // Read ports: merge sweep or the accepted request.
    assign fh_re    = i_cmd.merge_rd | (i_cmd.byte_acc & r_in_payload & is_print);
    assign fh_raddr = i_cmd.merge_rd ? r_cnt : code_off[AW-1:0];
    assign gh_re    = i_cmd.merge_rd | i_cmd.rd_acc;
    assign gh_raddr = i_cmd.merge_rd ? r_cnt : idx_ext[AW-1:0];

    // The merge write comes in the cycle after its read and also clears the frame bin.
    assign fh_we    = i_cmd.clr_wr | i_cmd.hist_upd | r_mwr;
    assign fh_waddr = i_cmd.hist_upd ? r_k : (r_mwr ? r_mwr_addr : r_cnt);
    assign fh_wdata = i_cmd.hist_upd ? sat_add(r_fh_q, CW'(1)) : '0;
    assign gh_we    = i_cmd.clr_wr | r_mwr;
    assign gh_waddr = r_mwr ? r_mwr_addr : r_cnt;
    assign gh_wdata = r_mwr ? sat_add(r_gh_q, r_fh_q) : '0;

    always_ff @(posedge i_clk) begin
        if (fh_re) r_fh_q <= mem_fh[fh_raddr];
        if (fh_we) mem_fh[fh_waddr] <= fh_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (gh_re) r_gh_q <= mem_gh[gh_raddr];
        if (gh_we) mem_gh[gh_waddr] <= gh_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.byte_acc) r_k <= code_off[AW-1:0];
        if (i_cmd.rd_acc) r_idx_ok <= idx_ok;
        r_mwr_addr <= r_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_mwr <= 1'b0;
        end else begin
            r_mwr <= i_cmd.merge_rd;
            if (sweep_step) begin
                r_cnt <= (r_cnt == LAST_ADDR) ? '0 : r_cnt + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_payload     <= 1'b0;
            r_digits_stopped <= 1'b0;
            r_len            <= '0;
            r_seen           <= '0;
            r_printable      <= '0;
            r_gbytes         <= '0;
        end else if (i_cmd.load_fin) begin
            r_in_payload     <= 1'b0;
            r_digits_stopped <= 1'b0;
            r_len            <= '0;
            r_seen           <= '0;
            r_printable      <= '0;
            r_gbytes         <= gbytes_next;
        end else begin
            if (i_cmd.byte_acc) begin
                if (r_in_payload) begin
                    r_seen <= sat_add(r_seen, CW'(1));
                end else if (is_mark) begin
                    r_in_payload <= 1'b1;
                end else if (!r_digits_stopped && is_digit) begin
                    r_len <= len_next;
                end else begin
                    r_digits_stopped <= 1'b1;
                end
            end
            if (i_cmd.hist_upd) begin
                r_printable <= sat_add(r_printable, CW'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_rd || i_cmd.load_fin) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_rd) begin
            r_kind      <= lpph_pkg::KIND_READ;
            r_out_pc    <= '0;
            r_out_bin   <= r_idx_ok ? low_out(r_gh_q) : '0;
            r_out_total <= low_out(r_gbytes);
        end else if (i_cmd.load_fin) begin
            r_kind      <= lpph_pkg::KIND_FRAME;
            r_out_pc    <= low_out(r_printable);
            r_out_bin   <= '0;
            r_out_total <= low_out(gbytes_next);
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_kind            = r_kind;
    assign o_printable_count = r_out_pc;
    assign o_bin_value       = r_out_bin;
    assign o_payload_total   = r_out_total;

endmodule

// ----- hw/rtl/length_prefixed_printable_histogram_top.sv -----
// Frame byte stream in, frame and bin-read results out.
// Input channel (i_in_valid / o_in_ready): each request is either a stream
// byte (i_op = 0, i_data_byte) or a read of one global histogram bin
// (i_op = 1, i_bin_index). A frame is a decimal length, '#', then that many
// payload bytes. Output channel (o_out_valid / i_out_ready) returns one
// result per finished frame (printable count and updated byte total) and
// one per bin read (bin count and byte total).
// A length-prefix byte is taken in the idle state. A '#' after an empty
// length goes straight to the frame result; a payload byte passes a check
// for the frame end, after a read-modify-write of its frame bin if it is
// printable. After the last payload byte of a frame, the frame histogram is
// merged into the global one and cleared, one bin per cycle, each bin read
// and then written through the separate read and write ports of its memory.
// A result is registered and shown in the cycle after the work making it.
// After reset both histograms are cleared by a pass over all NUM_BINS bins,
// during which o_in_ready is low. While the receiver stalls, requests that
// make no result are still taken; one that makes a result is taken, and the
// input then stays closed until the output register frees up.
module length_prefixed_printable_histogram_top #(
    parameter int NUM_BINS    = 95,
    parameter int COUNT_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_op,
    input  logic [7:0]  i_data_byte,
    input  logic [6:0]  i_bin_index,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_kind,
    output logic [31:0] o_printable_count,
    output logic [31:0] o_bin_value,
    output logic [31:0] o_payload_total
);

    lpph_pkg::t_cmd  cmd;
    lpph_pkg::t_stat stat;

    lpph_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    lpph_dp #(
        .NUM_BINS    (NUM_BINS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_op              (i_op),
        .i_data_byte       (i_data_byte),
        .i_bin_index       (i_bin_index),
        .i_out_ready       (i_out_ready),
        .o_out_valid       (o_out_valid),
        .o_kind            (o_kind),
        .o_printable_count (o_printable_count),
        .o_bin_value       (o_bin_value),
        .o_payload_total   (o_payload_total)
    );

    // The clearing pass keeps the input closed right after reset.
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready)
        else $error("request taken during the clearing pass");

    a_frame_no_bin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == lpph_pkg::KIND_FRAME) |-> o_bin_value == '0)
        else $error("frame result carries a bin value");

    a_read_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == lpph_pkg::KIND_READ) |-> o_printable_count == '0)
        else $error("bin read result carries a printable count");

    a_merge_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.merge_rd || cmd.hist_upd) |-> !o_in_ready)
        else $error("request taken while histogram memories are busy");

endmodule
